FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SBPKE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Condition that must never be seen outside reset.
`define SBPKE_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

FILE: rtl/sbpke_pkg.sv
// Package: types, register indexes, button bits and scan table for the pad key block.
package sbpke_pkg;

	localparam int WORD_W = 13;
	localparam int BUTTON_COUNT = 12;
	localparam int BIT_IDX_W = $clog2(WORD_W);

	// Button word bit positions
	localparam logic [BIT_IDX_W-1:0] BIT_UP      = 4'd0;
	localparam logic [BIT_IDX_W-1:0] BIT_DOWN    = 4'd1;
	localparam logic [BIT_IDX_W-1:0] BIT_LEFT    = 4'd2;
	localparam logic [BIT_IDX_W-1:0] BIT_RIGHT   = 4'd3;
	localparam logic [BIT_IDX_W-1:0] BIT_B       = 4'd4;
	localparam logic [BIT_IDX_W-1:0] BIT_C       = 4'd5;
	localparam logic [BIT_IDX_W-1:0] BIT_A       = 4'd6;
	localparam logic [BIT_IDX_W-1:0] BIT_START   = 4'd7;
	localparam logic [BIT_IDX_W-1:0] BIT_Z       = 4'd8;
	localparam logic [BIT_IDX_W-1:0] BIT_Y       = 4'd9;
	localparam logic [BIT_IDX_W-1:0] BIT_X       = 4'd10;
	localparam logic [BIT_IDX_W-1:0] BIT_MODE    = 4'd11;
	localparam logic [BIT_IDX_W-1:0] BIT_PRESENT = 4'd12;

	// Key codes
	localparam logic [3:0] KEY_LEFT  = 4'd0;
	localparam logic [3:0] KEY_RIGHT = 4'd1;
	localparam logic [3:0] KEY_UP    = 4'd2;
	localparam logic [3:0] KEY_DOWN  = 4'd3;
	localparam logic [3:0] KEY_START = 4'd4;
	localparam logic [3:0] KEY_MODE  = 4'd5;
	localparam logic [3:0] KEY_A     = 4'd6;
	localparam logic [3:0] KEY_B     = 4'd7;
	localparam logic [3:0] KEY_C     = 4'd8;
	localparam logic [3:0] KEY_X     = 4'd9;
	localparam logic [3:0] KEY_Y     = 4'd10;
	localparam logic [3:0] KEY_Z     = 4'd11;
	localparam logic [3:0] KEY_MAX   = KEY_Z;

	// Scan order, highest priority first
	localparam logic [BIT_IDX_W-1:0] SCAN_BIT [BUTTON_COUNT] = '{
		BIT_UP, BIT_DOWN, BIT_LEFT, BIT_RIGHT, BIT_START, BIT_A,
		BIT_B, BIT_C, BIT_X, BIT_Y, BIT_Z, BIT_MODE
	};
	localparam logic [3:0] SCAN_CODE [BUTTON_COUNT] = '{
		KEY_UP, KEY_DOWN, KEY_LEFT, KEY_RIGHT, KEY_START, KEY_A,
		KEY_B, KEY_C, KEY_X, KEY_Y, KEY_Z, KEY_MODE
	};
	localparam logic SCAN_LONG [BUTTON_COUNT] = '{
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
		1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1
	};

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_READ_INTERVAL = 2'd0,
		REG_SHORT_HOLD    = 2'd1,
		REG_LONG_HOLD     = 2'd2
	} cfg_reg_t;

	localparam logic [7:0] READ_INTERVAL_RST = 8'd5;
	localparam logic [7:0] SHORT_HOLD_RST    = 8'd25;
	localparam logic [7:0] LONG_HOLD_RST     = 8'd50;

	typedef struct packed {
		logic [7:0] read_interval_ms;
		logic [7:0] short_hold_ms;
		logic [7:0] long_hold_ms;
	} cfg_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic [5:0]  pins_phase_two;
		logic [5:0]  pins_phase_three;
		logic [5:0]  pins_phase_four;
		logic [5:0]  pins_phase_five;
	} in_item_t;

	typedef struct packed {
		logic [3:0] key_code;
		logic       pressed;
	} out_item_t;

endpackage

FILE: rtl/sbpke_decode.sv
// Six-button pad protocol decoder: phase pin samples to button word.
module sbpke_decode (
	input  logic [5:0]                  pins_phase_two,
	input  logic [5:0]                  pins_phase_three,
	input  logic [5:0]                  pins_phase_four,
	input  logic [5:0]                  pins_phase_five,
	output logic [sbpke_pkg::WORD_W-1:0] word
);

	logic [5:0] lo2, lo3, lo4, lo5;
	logic       present;
	logic       six;

	assign lo2 = ~pins_phase_two;
	assign lo3 = ~pins_phase_three;
	assign lo4 = ~pins_phase_four;
	assign lo5 = ~pins_phase_five;

	assign present = lo2[2] & lo2[3];
	assign six     = lo4[0] & lo4[1];

	always_comb begin
		word = '0;
		word[sbpke_pkg::BIT_PRESENT] = present;
		word[sbpke_pkg::BIT_A]       = present & lo2[4];
		word[sbpke_pkg::BIT_START]   = present & lo2[5];
		word[sbpke_pkg::BIT_UP]      = lo3[0];
		word[sbpke_pkg::BIT_DOWN]    = lo3[1];
		word[sbpke_pkg::BIT_LEFT]    = lo3[2];
		word[sbpke_pkg::BIT_RIGHT]   = lo3[3];
		word[sbpke_pkg::BIT_B]       = lo3[4];
		word[sbpke_pkg::BIT_C]       = lo3[5];
		// extra buttons only read when phase four of the same poll shows six-button mode
		word[sbpke_pkg::BIT_Z]       = six & lo5[0];
		word[sbpke_pkg::BIT_Y]       = six & lo5[1];
		word[sbpke_pkg::BIT_X]       = six & lo5[2];
		word[sbpke_pkg::BIT_MODE]    = six & lo5[3];
	end

endmodule

FILE: rtl/sbpke_event.sv
// Button state tracking, read throttle and debounced press/release selection.
module sbpke_event (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [31:0]                   now_ms,
	input  logic [sbpke_pkg::WORD_W-1:0]  fresh_word,
	input  sbpke_pkg::cfg_t               cfg,
	output logic                          evt_valid,
	output sbpke_pkg::out_item_t          evt_item
);

	logic [sbpke_pkg::WORD_W-1:0] cached_q;
	logic [sbpke_pkg::WORD_W-1:0] prev_q;
	logic [31:0]                  last_decode_q;
	logic [31:0]                  last_event_q;

	logic [31:0]                  since_decode;
	logic [31:0]                  since_event;
	logic                         take_fresh;
	logic [sbpke_pkg::WORD_W-1:0] word;
	logic [sbpke_pkg::WORD_W-1:0] changed;
	logic                         gap_short;
	logic                         gap_long;

	assign since_decode = now_ms - last_decode_q;
	assign since_event  = now_ms - last_event_q;
	assign take_fresh   = since_decode >= {24'd0, cfg.read_interval_ms};
	assign word         = take_fresh ? fresh_word : cached_q;
	assign changed      = word ^ prev_q;
	// zero hold still needs a nonzero gap: strict compare
	assign gap_short    = since_event > {24'd0, cfg.short_hold_ms};
	assign gap_long     = since_event > {24'd0, cfg.long_hold_ms};

	always_comb begin
		logic found;
		logic gap_ok;
		found    = 1'b0;
		evt_item = '0;
		for (int i = 0; i < sbpke_pkg::BUTTON_COUNT; i++) begin
			gap_ok = sbpke_pkg::SCAN_LONG[i] ? gap_long : gap_short;
			if (!found && changed[sbpke_pkg::SCAN_BIT[i]] && gap_ok) begin
				found             = 1'b1;
				evt_item.key_code = sbpke_pkg::SCAN_CODE[i];
				evt_item.pressed  = word[sbpke_pkg::SCAN_BIT[i]];
			end
		end
		evt_valid = found;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cached_q      <= '0;
			prev_q        <= '0;
			last_decode_q <= '0;
			last_event_q  <= '0;
		end else if (fire) begin
			prev_q <= word;
			if (take_fresh) begin
				cached_q      <= fresh_word;
				last_decode_q <= now_ms;
			end
			if (evt_valid) begin
				last_event_q <= now_ms;
			end
		end
	end

endmodule

FILE: rtl/six_button_pad_key_events.sv
// Top level of the six-button pad key event block.
//
//  port group   dir  handshake            payload
//  in_*         in   in_valid/in_ready    in_item  (sbpke_pkg::in_item_t)
//  out_*        out  out_valid/out_ready  out_item (sbpke_pkg::out_item_t)
//  cfg_*        in   cfg_we               cfg_index, cfg_data
//
// One poll per cycle sustained while the result is not stalled.
// Input register, then decode/compare/priority logic into the result register.
// A stalled result holds the input register; polls that make no event just retire.
// Reset clears valids, pad history and timestamps and loads the register defaults.
module six_button_pad_key_events (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sbpke_pkg::in_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sbpke_pkg::out_item_t out_item,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [7:0]           cfg_data
);

	sbpke_pkg::in_item_t          item_s1;
	logic                         valid_s1;
	sbpke_pkg::cfg_t              cfg_q;
	logic [sbpke_pkg::WORD_W-1:0] fresh_word;
	logic                         advance;
	logic                         evt_valid;
	sbpke_pkg::out_item_t         evt_item;
	logic                         out_valid_q;
	sbpke_pkg::out_item_t         out_item_q;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.read_interval_ms <= sbpke_pkg::READ_INTERVAL_RST;
			cfg_q.short_hold_ms    <= sbpke_pkg::SHORT_HOLD_RST;
			cfg_q.long_hold_ms     <= sbpke_pkg::LONG_HOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sbpke_pkg::REG_READ_INTERVAL: cfg_q.read_interval_ms <= cfg_data;
				sbpke_pkg::REG_SHORT_HOLD:    cfg_q.short_hold_ms    <= cfg_data;
				sbpke_pkg::REG_LONG_HOLD:     cfg_q.long_hold_ms     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	sbpke_decode u_decode (
		.pins_phase_two   (item_s1.pins_phase_two),
		.pins_phase_three (item_s1.pins_phase_three),
		.pins_phase_four  (item_s1.pins_phase_four),
		.pins_phase_five  (item_s1.pins_phase_five),
		.word             (fresh_word)
	);

	sbpke_event u_event (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (advance),
		.now_ms     (item_s1.now_ms),
		.fresh_word (fresh_word),
		.cfg        (cfg_q),
		.evt_valid  (evt_valid),
		.evt_item   (evt_item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= evt_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && evt_valid) begin
			out_item_q <= evt_item;
		end
	end

endmodule

FILE: rtl/sbpke_checker.sv
// Port-level checker for the pad key event block, bound to the top level.
`include "assert_macros.svh"

module sbpke_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input sbpke_pkg::out_item_t out_item
);

	`SBPKE_ASSERT(a_out_hold, clk, arst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_item)), "result changed or dropped while stalled")
	`SBPKE_NEVER(a_code_range, clk, arst_n, out_valid && (out_item.key_code > sbpke_pkg::KEY_MAX), "key code out of range")
	`SBPKE_ASSERT(a_ready_when_empty, clk, arst_n, !out_valid |-> in_ready, "input stalled with empty output")
	`SBPKE_ASSERT(a_result_has_cause, clk, arst_n, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without a poll two cycles earlier")

endmodule

bind six_button_pad_key_events sbpke_checker u_sbpke_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
